/* hw/rtl/ptcb_pkg.sv */
// Shared types and constants for the point tile crop and bounding box block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ptcb_pkg;

    // Width of the configuration write port and of the register index.
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_X_PAIR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_Y_PAIR  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_Z_PAIR  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_X_PAIR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_Y_PAIR  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFER_WIDTH = 3'd6;

    // Bits of the filter mode register.
    localparam int FILTER_XY_BIT = 0;
    localparam int FILTER_Z_BIT  = 1;

    // One input item.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               end_of_task;
    } t_point_in;

    // One result item.
    typedef struct packed {
        logic               keep;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic        [31:0] kept_total;
        logic               box_empty;
        logic               task_done;
    } t_box_out;

    // Window settings seen by the classifier. Tile bounds already include
    // the buffer margin, so they need one bit more than the raw pairs.
    typedef struct packed {
        logic        [1:0]  filter_mode;
        logic signed [31:0] crop_x_lo;
        logic signed [31:0] crop_x_hi;
        logic signed [31:0] crop_y_lo;
        logic signed [31:0] crop_y_hi;
        logic signed [31:0] crop_z_lo;
        logic signed [31:0] crop_z_hi;
        logic signed [32:0] tile_x_lo;
        logic signed [32:0] tile_x_hi;
        logic signed [32:0] tile_y_lo;
        logic signed [32:0] tile_y_hi;
    } t_window_cfg;

    // A classified point as it waits in the queue between front and back.
    typedef struct packed {
        logic        keep;
        logic        end_of_task;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
    } t_cls_item;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic head_valid;
    } t_queue_status;

endpackage

`default_nettype wire

/* hw/rtl/ptcb_front.sv */
// Front classifier: applies the crop filter and the buffered tile test to one point.
// Depends on ptcb_pkg.
`default_nettype none

module ptcb_front
    import ptcb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire t_point_in   i_point,
    input  wire t_window_cfg i_cfg,
    output t_cls_item        o_item
);

    localparam int CMP_W = ((COORD_BITS > 32) ? COORD_BITS : 32) + 2;

    logic [COORD_BITS-1:0] cx, cy, cz;
    logic signed [CMP_W-1:0] x, y, z;
    logic crop_pass;
    logic tile_pass;

    // Fold the 32-bit fields into the coordinate grid width.
    if (COORD_BITS <= 32) begin : g_narrow
        assign cx = i_point.point_x[COORD_BITS-1:0];
        assign cy = i_point.point_y[COORD_BITS-1:0];
        assign cz = i_point.point_z[COORD_BITS-1:0];
    end else begin : g_wide
        assign cx = {{(COORD_BITS-32){1'b0}}, i_point.point_x};
        assign cy = {{(COORD_BITS-32){1'b0}}, i_point.point_y};
        assign cz = {{(COORD_BITS-32){1'b0}}, i_point.point_z};
    end

    assign x = $signed({{(CMP_W-COORD_BITS){cx[COORD_BITS-1]}}, cx});
    assign y = $signed({{(CMP_W-COORD_BITS){cy[COORD_BITS-1]}}, cy});
    assign z = $signed({{(CMP_W-COORD_BITS){cz[COORD_BITS-1]}}, cz});

    function automatic logic in_range(input logic signed [CMP_W-1:0] v,
                                      input logic signed [32:0] lo,
                                      input logic signed [32:0] hi);
        logic signed [CMP_W-1:0] lo_e;
        logic signed [CMP_W-1:0] hi_e;
        lo_e = $signed({{(CMP_W-33){lo[32]}}, lo});
        hi_e = $signed({{(CMP_W-33){hi[32]}}, hi});
        return (v >= lo_e) && (v <= hi_e);
    endfunction

    always_comb begin
        if (i_cfg.filter_mode[FILTER_XY_BIT]) begin
            crop_pass = in_range(x, {i_cfg.crop_x_lo[31], i_cfg.crop_x_lo},
                                 {i_cfg.crop_x_hi[31], i_cfg.crop_x_hi})
                     && in_range(y, {i_cfg.crop_y_lo[31], i_cfg.crop_y_lo},
                                 {i_cfg.crop_y_hi[31], i_cfg.crop_y_hi});
        end else if (i_cfg.filter_mode[FILTER_Z_BIT]) begin
            crop_pass = in_range(z, {i_cfg.crop_z_lo[31], i_cfg.crop_z_lo},
                                 {i_cfg.crop_z_hi[31], i_cfg.crop_z_hi});
        end else begin
            crop_pass = 1'b1;
        end
    end

    assign tile_pass = in_range(x, i_cfg.tile_x_lo, i_cfg.tile_x_hi)
                    && in_range(y, i_cfg.tile_y_lo, i_cfg.tile_y_hi);

    assign o_item.keep        = crop_pass && tile_pass;
    assign o_item.end_of_task = i_point.end_of_task;
    assign o_item.point_x     = i_point.point_x;
    assign o_item.point_y     = i_point.point_y;
    assign o_item.point_z     = i_point.point_z;

endmodule

`default_nettype wire

/* hw/rtl/ptcb_queue.sv */
// Two-entry queue that holds classified points between front and back.
// Depends on ptcb_pkg.
`default_nettype none

module ptcb_queue
    import ptcb_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire t_cls_item i_item,
    input  wire            i_pop,
    output t_cls_item      o_head,
    output t_queue_status  o_status
);

    t_cls_item  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.full       = r_count[1];
    assign o_status.head_valid = (r_count != 2'd0);

endmodule

`default_nettype wire

/* hw/rtl/ptcb_back.sv */
// Back end: updates the running box and kept count, and holds the result register.
// Depends on ptcb_pkg.
`default_nettype none

module ptcb_back
    import ptcb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_cls_item i_head,
    input  wire            i_head_valid,
    output logic           o_pop,
    input  wire            i_out_stall,
    output logic           o_out_valid,
    output t_box_out       o_out_box
);

    localparam int CMP_W = ((COORD_BITS > 32) ? COORD_BITS : 32) + 2;
    localparam logic [COORD_BITS-1:0] COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [COORD_BITS-1:0] cx, cy, cz;

    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [COORD_BITS-1:0] r_max_x, r_max_y, r_max_z;
    logic signed [COORD_BITS-1:0] n_min_x, n_min_y, n_min_z;
    logic signed [COORD_BITS-1:0] n_max_x, n_max_y, n_max_z;
    logic [31:0] r_count, n_count;
    logic        r_none, n_none;

    logic     r_out_valid;
    t_box_out r_out, n_out;

    if (COORD_BITS <= 32) begin : g_narrow
        assign cx = i_head.point_x[COORD_BITS-1:0];
        assign cy = i_head.point_y[COORD_BITS-1:0];
        assign cz = i_head.point_z[COORD_BITS-1:0];
    end else begin : g_wide
        assign cx = {{(COORD_BITS-32){1'b0}}, i_head.point_x};
        assign cy = {{(COORD_BITS-32){1'b0}}, i_head.point_y};
        assign cz = {{(COORD_BITS-32){1'b0}}, i_head.point_z};
    end

    function automatic logic [31:0] to_field(input logic [COORD_BITS-1:0] v);
        logic [CMP_W-1:0] e;
        e = {{(CMP_W-COORD_BITS){v[COORD_BITS-1]}}, v};
        return e[31:0];
    endfunction

    // Take the head whenever the result register is free or being emptied.
    assign o_pop = i_head_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_min_z = r_min_z;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        n_max_z = r_max_z;
        n_count = r_count;
        n_none  = r_none;
        if (i_head.keep) begin
            if ($signed(cx) < r_min_x) n_min_x = $signed(cx);
            if ($signed(cx) > r_max_x) n_max_x = $signed(cx);
            if ($signed(cy) < r_min_y) n_min_y = $signed(cy);
            if ($signed(cy) > r_max_y) n_max_y = $signed(cy);
            if ($signed(cz) < r_min_z) n_min_z = $signed(cz);
            if ($signed(cz) > r_max_z) n_max_z = $signed(cz);
            if (r_count != 32'hFFFF_FFFF) n_count = r_count + 32'd1;
            n_none = 1'b0;
        end
    end

    always_comb begin
        n_out.keep        = i_head.keep;
        n_out.kept_total  = n_count;
        n_out.box_empty   = n_none;
        n_out.task_done   = i_head.end_of_task;
        if (n_none) begin
            n_out.box_min_x = '0;
            n_out.box_min_y = '0;
            n_out.box_min_z = '0;
            n_out.box_max_x = '0;
            n_out.box_max_y = '0;
            n_out.box_max_z = '0;
        end else begin
            n_out.box_min_x = to_field(n_min_x);
            n_out.box_min_y = to_field(n_min_y);
            n_out.box_min_z = to_field(n_min_z);
            n_out.box_max_x = to_field(n_max_x);
            n_out.box_max_y = to_field(n_max_y);
            n_out.box_max_z = to_field(n_max_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= COORD_TOP;
            r_min_y <= COORD_TOP;
            r_min_z <= COORD_TOP;
            r_max_x <= COORD_BOT;
            r_max_y <= COORD_BOT;
            r_max_z <= COORD_BOT;
            r_count <= '0;
            r_none  <= 1'b1;
        end else if (o_pop) begin
            if (i_head.end_of_task) begin
                r_min_x <= COORD_TOP;
                r_min_y <= COORD_TOP;
                r_min_z <= COORD_TOP;
                r_max_x <= COORD_BOT;
                r_max_y <= COORD_BOT;
                r_max_z <= COORD_BOT;
                r_count <= '0;
                r_none  <= 1'b1;
            end else begin
                r_min_x <= n_min_x;
                r_min_y <= n_min_y;
                r_min_z <= n_min_z;
                r_max_x <= n_max_x;
                r_max_y <= n_max_y;
                r_max_z <= n_max_z;
                r_count <= n_count;
                r_none  <= n_none;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_box   = r_out;

endmodule

`default_nettype wire

/* hw/rtl/point_tile_crop_bbox.sv */
// Top level of the point tile crop and bounding box block.
// Depends on ptcb_pkg, ptcb_front, ptcb_queue and ptcb_back.
`default_nettype none

// Channel   | Handshake                        | Payload
// ----------+----------------------------------+--------------------------
// points in | i_in_valid / o_in_stall          | i_in_point  (t_point_in)
// box out   | o_out_valid / i_out_stall        | o_out_box   (t_box_out)
// config    | i_cfg_we, i_cfg_idx              | i_cfg_wdata (64 bits)
//
// The block takes one item per cycle while o_in_stall is low and returns
// one result per item; an item passes the queue and then the result register.
// The rate is set by the back end's running min/max update loop.
// Reset is synchronous and active low; it clears the registers, the queue
// and the running box. While reset is held the input stalls and no result
// is offered. Outside reset o_in_stall rises only when the two-entry queue
// is full, so an output stall reaches the input after at most two further items.

module point_tile_crop_bbox
    import ptcb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire t_point_in          i_in_point,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output t_box_out                o_out_box,
    input  wire                     i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    // Configuration registers, as written through the port.
    logic [1:0]  r_filter_mode;
    logic [63:0] r_crop_x_pair;
    logic [63:0] r_crop_y_pair;
    logic [63:0] r_crop_z_pair;
    logic [63:0] r_tile_x_pair;
    logic [63:0] r_tile_y_pair;
    logic [30:0] r_buffer_width;

    // Tile window with the buffer margin applied. These follow the raw
    // registers in the same cycle, so a point right after a write sees it.
    logic signed [32:0] tile_x_lo, tile_x_hi;
    logic signed [32:0] tile_y_lo, tile_y_hi;

    t_window_cfg   win_cfg;
    t_cls_item     front_item;
    t_cls_item     head_item;
    t_queue_status q_status;
    logic          push;
    logic          pop;
    logic          back_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= '0;
            r_crop_x_pair  <= '0;
            r_crop_y_pair  <= '0;
            r_crop_z_pair  <= '0;
            r_tile_x_pair  <= '0;
            r_tile_y_pair  <= '0;
            r_buffer_width <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_MODE:  r_filter_mode  <= i_cfg_wdata[1:0];
                CFG_CROP_X_PAIR:  r_crop_x_pair  <= i_cfg_wdata;
                CFG_CROP_Y_PAIR:  r_crop_y_pair  <= i_cfg_wdata;
                CFG_CROP_Z_PAIR:  r_crop_z_pair  <= i_cfg_wdata;
                CFG_TILE_X_PAIR:  r_tile_x_pair  <= i_cfg_wdata;
                CFG_TILE_Y_PAIR:  r_tile_y_pair  <= i_cfg_wdata;
                CFG_BUFFER_WIDTH: r_buffer_width <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tile_x_lo = $signed({r_tile_x_pair[31], r_tile_x_pair[31:0]})
                  - $signed({2'b00, r_buffer_width});
        tile_x_hi = $signed({r_tile_x_pair[63], r_tile_x_pair[63:32]})
                  + $signed({2'b00, r_buffer_width});
        tile_y_lo = $signed({r_tile_y_pair[31], r_tile_y_pair[31:0]})
                  - $signed({2'b00, r_buffer_width});
        tile_y_hi = $signed({r_tile_y_pair[63], r_tile_y_pair[63:32]})
                  + $signed({2'b00, r_buffer_width});
    end

    always_comb begin
        win_cfg.filter_mode = r_filter_mode;
        win_cfg.crop_x_lo   = $signed(r_crop_x_pair[31:0]);
        win_cfg.crop_x_hi   = $signed(r_crop_x_pair[63:32]);
        win_cfg.crop_y_lo   = $signed(r_crop_y_pair[31:0]);
        win_cfg.crop_y_hi   = $signed(r_crop_y_pair[63:32]);
        win_cfg.crop_z_lo   = $signed(r_crop_z_pair[31:0]);
        win_cfg.crop_z_hi   = $signed(r_crop_z_pair[63:32]);
        win_cfg.tile_x_lo   = tile_x_lo;
        win_cfg.tile_x_hi   = tile_x_hi;
        win_cfg.tile_y_lo   = tile_y_lo;
        win_cfg.tile_y_hi   = tile_y_hi;
    end

    // The front classifies each point as it arrives and writes the verdict
    // into the queue in the same cycle.
    ptcb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_point (i_in_point),
        .i_cfg   (win_cfg),
        .o_item  (front_item)
    );

    // No item is taken while reset is held.
    assign o_in_stall = q_status.full || !i_rst_n;
    assign push       = i_in_valid && !o_in_stall;

    ptcb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // The back owns the running box and the result register.
    ptcb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_item),
        .i_head_valid (q_status.head_valid),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (back_valid),
        .o_out_box    (o_out_box)
    );

    // A result is offered only outside reset.
    assign o_out_valid = back_valid && i_rst_n;

endmodule

`default_nettype wire

/* hw/rtl/ptcb_checker.sv */
// Port-level checks on the result channel of the point tile crop block.
// Depends on ptcb_pkg; bound to point_tile_crop_bbox below.
`default_nettype none

module ptcb_checker
    import ptcb_pkg::*;
(
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_out_valid,
    input wire           i_out_stall,
    input wire t_box_out i_out_box
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_box))
        else $error("result changed while stalled");

    // No result shows up in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An empty box means nothing kept and zero box fields (min x and max z are checked).
    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_box.box_empty |->
            !i_out_box.keep && (i_out_box.kept_total == 32'd0)
            && (i_out_box.box_min_x == 32'sd0) && (i_out_box.box_max_z == 32'sd0))
        else $error("empty box with kept points or box data");

    // A kept point always leaves a non-empty box and a nonzero count.
    a_keep_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_box.keep |->
            !i_out_box.box_empty && (i_out_box.kept_total != 32'd0))
        else $error("kept point not reflected in box");

endmodule

bind point_tile_crop_bbox ptcb_checker u_ptcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_box   (o_out_box)
);

`default_nettype wire
